>>> design/rdp_pkg.sv
// Shared types, constants and modular step functions for the RNS dot product unit.
package rdp_pkg;

    localparam int WORD_W    = 32;
    localparam int CNT_W     = $clog2(WORD_W);
    localparam int CFG_IDX_W = 2;
    localparam int RST_W     = 31;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_MODULUS  = 2'd0,
        CFG_SECOND_MODULUS = 2'd1,
        CFG_GARNER_INVERSE = 2'd2
    } t_cfg_idx;

    localparam logic [RST_W-1:0] FIRST_MODULUS_RST  = 31'd2147483647;
    localparam logic [RST_W-1:0] SECOND_MODULUS_RST = 31'd2147483629;
    localparam logic [RST_W-1:0] GARNER_INVERSE_RST = 31'd2028178983;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_NEGATE,
        ST_ADD,
        ST_G_LOAD,
        ST_G_RED,
        ST_G_DIFF,
        ST_G_MUL,
        ST_G_FULL,
        ST_G_PROD,
        ST_G_X,
        ST_G_CMP,
        ST_G_SUB,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic reduce;
        logic mul;
        logic negate;
        logic add;
        logic clear;
    } t_lane_ctl;

    // r < m: shift in one bit, reduce once
    function automatic t_word mod_shift_in(t_word r, logic b, t_word m);
        t_word t;
        t = {r[WORD_W-2:0], b};
        if (t >= m) t = t - m;
        return t;
    endfunction

    // r, addend < m: double, optionally add, reduce after each
    function automatic t_word mod_dbl_add(t_word r, logic sel, t_word addend, t_word m);
        t_word t;
        t = {r[WORD_W-2:0], 1'b0};
        if (t >= m) t = t - m;
        if (sel) t = t + addend;
        if (t >= m) t = t - m;
        return t;
    endfunction

endpackage

>>> design/rdp_ring_lane.sv
// One residue ring: bit-serial operand reduction, modular multiply and running sum.
module rdp_ring_lane #(
    parameter int RESIDUE_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [RESIDUE_BITS-1:0] i_modulus,
    input  rdp_pkg::t_lane_ctl      i_ctl,
    input  rdp_pkg::t_word          i_a_mag,
    input  rdp_pkg::t_word          i_b_mag,
    input  logic                    i_neg,
    output logic [RESIDUE_BITS-1:0] o_sum
);
    import rdp_pkg::*;

    logic [RESIDUE_BITS-1:0] r_sum, n_sum;
    logic [RESIDUE_BITS-1:0] r_rb, n_rb;
    logic [RESIDUE_BITS-1:0] r_rs, n_rs;
    logic [RESIDUE_BITS-1:0] r_acc, n_acc;
    t_word                   r_ash;
    t_word                   r_bsh;
    t_word                   r_ssh;
    logic                    r_neg;

    always_comb begin
        t_word w_m;
        t_word w_rb;
        t_word w_rs;
        t_word w_acc;
        t_word w_tot;
        w_m   = t_word'(i_modulus);
        w_rb  = mod_shift_in(t_word'(r_rb), r_bsh[WORD_W-1], w_m);
        w_rs  = mod_shift_in(t_word'(r_rs), r_ssh[WORD_W-1], w_m);
        w_acc = mod_dbl_add(t_word'(r_acc), r_ash[WORD_W-1], t_word'(r_rb), w_m);
        w_tot = t_word'(r_rs) + t_word'(r_acc);
        if (w_tot >= w_m) w_tot = w_tot - w_m;
        n_rb  = w_rb[RESIDUE_BITS-1:0];
        n_rs  = w_rs[RESIDUE_BITS-1:0];
        n_acc = w_acc[RESIDUE_BITS-1:0];
        if (i_ctl.clear || i_modulus == '0) begin
            n_sum = '0;
        end else begin
            n_sum = w_tot[RESIDUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.add || i_ctl.clear) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ash <= i_a_mag;
            r_bsh <= i_b_mag;
            r_ssh <= t_word'(r_sum);
            r_neg <= i_neg;
            r_rb  <= '0;
            r_rs  <= '0;
            r_acc <= '0;
        end else if (i_ctl.reduce) begin
            r_rb  <= n_rb;
            r_rs  <= n_rs;
            r_bsh <= {r_bsh[WORD_W-2:0], 1'b0};
            r_ssh <= {r_ssh[WORD_W-2:0], 1'b0};
        end else if (i_ctl.mul) begin
            r_acc <= n_acc;
            r_ash <= {r_ash[WORD_W-2:0], 1'b0};
        end else if (i_ctl.negate) begin
            if (r_neg && r_acc != '0) begin
                r_acc <= i_modulus - r_acc;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

>>> design/rns_dot_product_crt_reconstruct_unit.sv
// Top level: two-modulus RNS dot product with Garner reconstruction.
// Each input word (one term) runs, from acceptance until the input is ready again, through
// a bit-serial reduction of the weight magnitude and the stored sum, then a bit-serial
// modular multiply over the activation magnitude, both in the two ring lanes in parallel,
// then a negate state to fold the sign and an add state into the sum. A term flagged last
// then also passes through the Garner unit:
// a bit-serial reduction of the first sum by the second modulus, a bit-serial modular multiply
// by the inverse, then one shared multiplier pass each for m1*m2 and h*m1, a compare and a
// subtract. A finished result sits in the output register while the next term is accepted;
// the block only waits when a new result is ready and the previous one is still untaken.
// Configuration writes are accepted at any time and must be made while the block is idle.
module rns_dot_product_crt_reconstruct_unit #(
    parameter int RESIDUE_BITS = 31
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [rdp_pkg::WORD_W-1:0]    i_operand_a,
    input  logic signed [rdp_pkg::WORD_W-1:0]    i_operand_b,
    input  logic                                 i_last_term,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [2*RESIDUE_BITS-1:0]     o_signed_value,
    output logic [RESIDUE_BITS-1:0]              o_first_residue,
    output logic [RESIDUE_BITS-1:0]              o_second_residue,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rdp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [RESIDUE_BITS-1:0]              i_cfg_data
);
    import rdp_pkg::*;

    localparam int PW = 2 * RESIDUE_BITS;

    t_state                  r_state, n_state;
    t_count                  r_cnt, n_cnt;
    logic [RESIDUE_BITS-1:0] r_m1;
    logic [RESIDUE_BITS-1:0] r_m2;
    logic [RESIDUE_BITS-1:0] r_ginv;
    logic                    r_last;
    logic [RESIDUE_BITS-1:0] r_gsh;
    logic [RESIDUE_BITS-1:0] r_gacc;
    logic [RESIDUE_BITS-1:0] r_gdiff;
    logic [PW-1:0]           r_prod;
    logic [PW-1:0]           r_full;
    logic [PW-1:0]           r_x;
    logic                    r_wrap;
    logic [PW-1:0]           r_val;
    logic                    r_out_valid;
    logic [PW-1:0]           r_out_value;
    logic [RESIDUE_BITS-1:0] r_out_r1;
    logic [RESIDUE_BITS-1:0] r_out_r2;

    t_lane_ctl               w_ctl;
    logic                    w_accept;
    logic                    w_out_load;
    t_word                   w_a_mag;
    t_word                   w_b_mag;
    logic                    w_neg;
    logic [RESIDUE_BITS-1:0] w_sum1;
    logic [RESIDUE_BITS-1:0] w_sum2;
    logic [RESIDUE_BITS-1:0] w_h;
    logic [RESIDUE_BITS-1:0] w_diff;
    logic [RESIDUE_BITS-1:0] w_gred_next;
    logic [RESIDUE_BITS-1:0] w_gmul_next;
    logic [RESIDUE_BITS-1:0] w_mul_a;
    logic [RESIDUE_BITS-1:0] w_mul_b;
    logic                    w_word_end;
    logic                    w_res_end;

    assign w_a_mag = i_operand_a[WORD_W-1] ? t_word'(-i_operand_a) : t_word'(i_operand_a);
    assign w_b_mag = i_operand_b[WORD_W-1] ? t_word'(-i_operand_b) : t_word'(i_operand_b);
    assign w_neg   = i_operand_a[WORD_W-1] ^ i_operand_b[WORD_W-1];

    rdp_ring_lane #(.RESIDUE_BITS(RESIDUE_BITS)) u_lane_first (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_m1),
        .i_ctl     (w_ctl),
        .i_a_mag   (w_a_mag),
        .i_b_mag   (w_b_mag),
        .i_neg     (w_neg),
        .o_sum     (w_sum1)
    );

    rdp_ring_lane #(.RESIDUE_BITS(RESIDUE_BITS)) u_lane_second (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_m2),
        .i_ctl     (w_ctl),
        .i_a_mag   (w_a_mag),
        .i_b_mag   (w_b_mag),
        .i_neg     (w_neg),
        .o_sum     (w_sum2)
    );

    assign w_word_end = (r_cnt == t_count'(WORD_W - 1));
    assign w_res_end  = (r_cnt == t_count'(RESIDUE_BITS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_REDUCE;
            ST_REDUCE: if (w_word_end) n_state = ST_MUL;
            ST_MUL:    if (w_word_end) n_state = ST_NEGATE;
            ST_NEGATE: n_state = ST_ADD;
            ST_ADD:    n_state = r_last ? ST_G_LOAD : ST_IDLE;
            ST_G_LOAD: n_state = ST_G_RED;
            ST_G_RED:  if (w_res_end) n_state = ST_G_DIFF;
            ST_G_DIFF: n_state = ST_G_MUL;
            ST_G_MUL:  if (w_res_end) n_state = ST_G_FULL;
            ST_G_FULL: n_state = ST_G_PROD;
            ST_G_PROD: n_state = ST_G_X;
            ST_G_X:    n_state = ST_G_CMP;
            ST_G_CMP:  n_state = ST_G_SUB;
            ST_G_SUB:  n_state = ST_DONE;
            ST_DONE:   if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_ctl      = '0;
        o_in_ready = 1'b0;
        w_out_load = 1'b0;
        n_cnt      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                w_ctl.load = i_in_valid;
            end
            ST_REDUCE: begin
                w_ctl.reduce = 1'b1;
                n_cnt        = w_word_end ? '0 : r_cnt + 1'b1;
            end
            ST_MUL: begin
                w_ctl.mul = 1'b1;
                n_cnt     = w_word_end ? '0 : r_cnt + 1'b1;
            end
            ST_NEGATE: w_ctl.negate = 1'b1;
            ST_ADD:    w_ctl.add = 1'b1;
            ST_G_RED:  n_cnt = w_res_end ? '0 : r_cnt + 1'b1;
            ST_G_MUL:  n_cnt = w_res_end ? '0 : r_cnt + 1'b1;
            ST_DONE: begin
                w_out_load  = !r_out_valid || i_out_ready;
                w_ctl.clear = w_out_load;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1   <= FIRST_MODULUS_RST[RESIDUE_BITS-1:0];
            r_m2   <= SECOND_MODULUS_RST[RESIDUE_BITS-1:0];
            r_ginv <= GARNER_INVERSE_RST[RESIDUE_BITS-1:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FIRST_MODULUS:  r_m1   <= i_cfg_data;
                CFG_SECOND_MODULUS: r_m2   <= i_cfg_data;
                CFG_GARNER_INVERSE: r_ginv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Garner datapath
    always_comb begin
        t_word w_red;
        t_word w_mm;
        logic [RESIDUE_BITS-1:0] w_r1m2;
        w_red       = mod_shift_in(t_word'(r_gacc), r_gsh[RESIDUE_BITS-1], t_word'(r_m2));
        w_mm        = mod_dbl_add(t_word'(r_gacc), r_gsh[RESIDUE_BITS-1], t_word'(r_gdiff),
                                  t_word'(r_m2));
        w_gred_next = w_red[RESIDUE_BITS-1:0];
        w_gmul_next = w_mm[RESIDUE_BITS-1:0];
        w_r1m2      = (r_m2 == '0) ? '0 : r_gacc;
        w_h         = (r_m2 == '0) ? '0 : r_gacc;
        if (w_sum2 >= w_r1m2) begin
            w_diff = w_sum2 - w_r1m2;
        end else begin
            w_diff = r_m2 - w_r1m2 + w_sum2;
        end
        if (r_state == ST_G_FULL) begin
            w_mul_a = r_m1;
            w_mul_b = r_m2;
        end else begin
            w_mul_a = w_h;
            w_mul_b = r_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_mul_a) * PW'(w_mul_b);
        if (w_accept) r_last <= i_last_term;
        case (r_state)
            ST_G_LOAD: begin
                r_gsh  <= w_sum1;
                r_gacc <= '0;
            end
            ST_G_RED: begin
                r_gacc <= w_gred_next;
                r_gsh  <= {r_gsh[RESIDUE_BITS-2:0], 1'b0};
            end
            ST_G_DIFF: begin
                r_gdiff <= w_diff;
                r_gsh   <= r_ginv;
                r_gacc  <= '0;
            end
            ST_G_MUL: begin
                r_gacc <= w_gmul_next;
                r_gsh  <= {r_gsh[RESIDUE_BITS-2:0], 1'b0};
            end
            ST_G_PROD: r_full <= r_prod;
            ST_G_X:    r_x    <= r_prod + PW'(w_sum1);
            ST_G_CMP:  r_wrap <= {r_x, 1'b0} > {1'b0, r_full};
            ST_G_SUB:  r_val  <= r_wrap ? r_x - r_full : r_x;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value <= r_val;
            r_out_r1    <= w_sum1;
            r_out_r2    <= w_sum2;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_signed_value   = r_out_value;
    assign o_first_residue  = r_out_r1;
    assign o_second_residue = r_out_r2;

    a_residues_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_G_DIFF && r_m1 != '0 && r_m2 != '0)
            |-> (w_sum1 < r_m1 && w_sum2 < r_m2 && r_gacc < r_m2))
        else $error("sums or r1 mod m2 not reduced before Garner step");

    a_x_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_G_CMP && r_m1 != '0 && r_m2 != '0) |-> (r_x < r_full))
        else $error("reconstructed value not below m1*m2");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result word raised outside the done state");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load) |=> (w_sum1 == '0 && w_sum2 == '0 && r_state == ST_IDLE))
        else $error("sums not cleared after result load");

endmodule
